FILE: design/enfa_pkg.sv
// enfa_pkg: shared types and codes for the epsilon-nfa step core
// holds the command and result words, function codes and sequencer states
// no dependencies
`default_nettype none

package enfa_pkg;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STEP  = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  from_state;
      logic [3:0]  symbol;
      logic        is_epsilon;
      logic [15:0] target_set;
   } enfa_cmd_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] state_set;
   } enfa_res_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_RD,
      ST_WR_WR,
      ST_CLOS_A,
      ST_MOVE,
      ST_CLOS_B,
      ST_FINISH
   } enfa_state_type;

endpackage

`default_nettype wire

FILE: design/enfa_table.sv
// enfa_table: transition table storage, one write port and one read port
// read data is registered; no dependencies
`default_nettype none

module enfa_table #(
   parameter int DEPTH = 272,
   parameter int AW    = 9,
   parameter int DW    = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/enfa_engine.sv
// enfa_engine: sequencer for table writes, epsilon closures and symbol moves
// owns the transition table (enfa_table) and the current state set; uses enfa_pkg
`default_nettype none

module enfa_engine #(
   parameter int NUM_STATES  = 16,
   parameter int NUM_SYMBOLS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   input  wire enfa_pkg::enfa_cmd_type cmd,
   input  wire logic [3:0]            init_state,
   input  wire logic                  rsp_free,
   output logic                       ready,
   output enfa_pkg::enfa_res_type     res
);

   localparam int ROW_COUNT = NUM_SYMBOLS + 1;
   localparam int EPS_ROW   = NUM_SYMBOLS;
   localparam int DEPTH     = NUM_STATES * ROW_COUNT;
   localparam int AW        = $clog2(DEPTH);
   localparam int SW        = $clog2(NUM_STATES);
   localparam int RW        = $clog2(ROW_COUNT);
   localparam int NS        = NUM_STATES;

   enfa_pkg::enfa_state_type state_ff, state_in;

   logic [NS-1:0] set_ff, set_in;
   logic [NS-1:0] done_ff, done_in;
   logic [NS-1:0] acc_ff, acc_in;
   logic [NS-1:0] cur_ff, cur_in;
   logic [NS-1:0] tgt_ff, tgt_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [SW-1:0] from_ff, from_in;
   logic [RW-1:0] row_ff, row_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          pend_ff, pend_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [NS-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [NS-1:0] mem_rdata;

   logic          wr_ok;
   logic          sym_ok;
   logic          init_ok;
   logic          issue;
   logic          fin;
   logic          clr_last;
   logic [NS-1:0] rd_or;
   logic [RW-1:0] scan_row;
   logic [AW-1:0] scan_addr;
   logic [AW-1:0] wr_addr;
   logic [SW-1:0] scan_next;

   enfa_table #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (NS)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign wr_ok    = (32'(cmd.from_state) < NUM_STATES) &&
                     (cmd.is_epsilon || (32'(cmd.symbol) < NUM_SYMBOLS));
   assign sym_ok   = 32'(cmd.symbol) < NUM_SYMBOLS;
   assign init_ok  = 32'(init_state) < NUM_STATES;
   assign issue    = set_ff[scan_ff] & ~done_ff[scan_ff];
   assign fin      = !pend_ff && ((set_ff & ~done_ff) == '0);
   assign clr_last = clr_ff == AW'(DEPTH - 1);
   assign rd_or    = pend_ff ? mem_rdata : '0;
   assign scan_row = (state_ff == enfa_pkg::ST_MOVE) ? row_ff : RW'(EPS_ROW);
   assign scan_addr = AW'(scan_ff) * AW'(ROW_COUNT) + AW'(scan_row);
   assign wr_addr   = AW'(from_ff) * AW'(ROW_COUNT) + AW'(row_ff);
   assign scan_next = (scan_ff == SW'(NUM_STATES - 1)) ? '0 : scan_ff + 1'b1;
   assign ready     = state_ff == enfa_pkg::ST_IDLE;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         enfa_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = enfa_pkg::ST_IDLE;
            end
         end
         enfa_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.func)
                  enfa_pkg::FUNC_WRITE: begin
                     state_in = wr_ok ? enfa_pkg::ST_WR_RD : enfa_pkg::ST_IDLE;
                  end
                  enfa_pkg::FUNC_START: begin
                     state_in = enfa_pkg::ST_CLOS_B;
                  end
                  enfa_pkg::FUNC_STEP: begin
                     state_in = sym_ok ? enfa_pkg::ST_CLOS_A : enfa_pkg::ST_CLOS_B;
                  end
                  default: begin
                     state_in = enfa_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         enfa_pkg::ST_WR_RD: begin
            state_in = enfa_pkg::ST_WR_WR;
         end
         enfa_pkg::ST_WR_WR: begin
            state_in = enfa_pkg::ST_IDLE;
         end
         enfa_pkg::ST_CLOS_A: begin
            if (fin) begin
               state_in = enfa_pkg::ST_MOVE;
            end
         end
         enfa_pkg::ST_MOVE: begin
            if (fin) begin
               state_in = enfa_pkg::ST_CLOS_B;
            end
         end
         enfa_pkg::ST_CLOS_B: begin
            if (fin) begin
               state_in = enfa_pkg::ST_FINISH;
            end
         end
         enfa_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = enfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = enfa_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      set_in    = set_ff;
      done_in   = done_ff;
      acc_in    = acc_ff;
      cur_in    = cur_ff;
      tgt_in    = tgt_ff;
      scan_in   = scan_ff;
      from_in   = from_ff;
      row_in    = row_ff;
      clr_in    = clr_ff;
      pend_in   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = wr_addr;
      mem_wdata = mem_rdata | tgt_ff;
      mem_raddr = scan_addr;
      res.valid     = 1'b0;
      res.state_set = 16'(set_ff);

      unique case (state_ff) inside
         enfa_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         enfa_pkg::ST_IDLE: begin
            done_in = '0;
            scan_in = '0;
            if (cmd_valid) begin
               unique case (cmd.func)
                  enfa_pkg::FUNC_WRITE: begin
                     from_in = SW'(cmd.from_state);
                     row_in  = cmd.is_epsilon ? RW'(EPS_ROW) : RW'(cmd.symbol);
                     tgt_in  = NS'(cmd.target_set);
                  end
                  enfa_pkg::FUNC_START: begin
                     set_in = init_ok ? (NS'(1) << init_state) : '0;
                  end
                  enfa_pkg::FUNC_STEP: begin
                     set_in = sym_ok ? cur_ff : '0;
                     row_in = RW'(cmd.symbol);
                  end
                  default: begin
                     set_in = set_ff;
                  end
               endcase
            end
         end
         enfa_pkg::ST_WR_RD: begin
            mem_raddr = wr_addr;
         end
         enfa_pkg::ST_WR_WR: begin
            mem_we = 1'b1;
         end
         enfa_pkg::ST_CLOS_A, enfa_pkg::ST_CLOS_B: begin
            set_in  = set_ff | rd_or;
            pend_in = issue;
            scan_in = scan_next;
            if (issue) begin
               done_in[scan_ff] = 1'b1;
            end
            if (fin) begin
               done_in = '0;
               scan_in = '0;
               acc_in  = '0;
               if (state_ff == enfa_pkg::ST_CLOS_B) begin
                  cur_in = set_ff;
               end
            end
         end
         enfa_pkg::ST_MOVE: begin
            acc_in  = acc_ff | rd_or;
            pend_in = issue;
            scan_in = scan_next;
            if (issue) begin
               done_in[scan_ff] = 1'b1;
            end
            if (fin) begin
               set_in  = acc_ff;
               done_in = '0;
               scan_in = '0;
            end
         end
         enfa_pkg::ST_FINISH: begin
            res.valid = rsp_free;
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= enfa_pkg::ST_CLEAR;
         clr_ff   <= '0;
         cur_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cur_ff   <= cur_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff  <= set_in;
      done_ff <= done_in;
      acc_ff  <= acc_in;
      tgt_ff  <= tgt_in;
      scan_ff <= scan_in;
      from_ff <= from_in;
      row_ff  <= row_in;
   end

endmodule

`default_nettype wire

FILE: design/epsilon_nfa_step_core.sv
// epsilon_nfa_step_core: top level of the epsilon-nfa simulation block
// holds the start-state register and the result word register; uses enfa_pkg, enfa_engine
//
//   port group   dir   handshake          payload
//   req_*        in    req_valid/stall    func, from_state, symbol, is_epsilon, target_set
//   rsp_*        out   rsp_valid/stall    state_set
//   csr_*        in    csr_write_enable   csr_write_data (initial state)
//
// a table write goes through accept, table read and merged write back.
// a closure visits each new member once, one state slot and one table read per cycle.
// a start is one closure; a step with a valid symbol is two closures around a symbol pass.
// reset clears the table one entry per cycle and holds req_stall until it is done;
// a finished word waits in the output register, and the core holds only while it is stalled.
`default_nettype none

module epsilon_nfa_step_core #(
   parameter int NUM_STATES  = 16,
   parameter int NUM_SYMBOLS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [3:0]  req_from_state,
   input  wire logic [3:0]  req_symbol,
   input  wire logic        req_is_epsilon,
   input  wire logic [15:0] req_target_set,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_state_set,
   input  wire logic        csr_write_enable,
   input  wire logic [3:0]  csr_write_data
);

   logic [3:0]  init_ff, init_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_set_ff, rsp_set_in;

   logic                   eng_ready;
   logic                   rsp_free;
   enfa_pkg::enfa_cmd_type cmd;
   enfa_pkg::enfa_res_type res;

   assign cmd.func       = req_func;
   assign cmd.from_state = req_from_state;
   assign cmd.symbol     = req_symbol;
   assign cmd.is_epsilon = req_is_epsilon;
   assign cmd.target_set = req_target_set;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !eng_ready;

   enfa_engine #(
      .NUM_STATES  (NUM_STATES),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_valid),
      .cmd        (cmd),
      .init_state (init_ff),
      .rsp_free   (rsp_free),
      .ready      (eng_ready),
      .res        (res)
   );

   always_comb begin
      init_in      = csr_write_enable ? csr_write_data : init_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_set_in   = rsp_set_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_set_in   = res.state_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_set_ff <= rsp_set_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_state_set = rsp_set_ff;

endmodule

`default_nettype wire
